// ===== rtl/rwam_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwam_pkg
// Shared types and constants for the signal-strength window average monitor.
// ----------------------------------------------------------------------------
package rwam_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SMP_W  = 8;
  localparam int SUM_W  = SMP_W + CNT_W;
  localparam int DIV_CW = $clog2(SUM_W);
  localparam int CMD_W  = 3;
  localparam int WIN_W  = 16;
  localparam int STAT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    OP_START   = 3'd0,
    OP_STOP    = 3'd1,
    OP_INSERT  = 3'd2,
    OP_LATEST  = 3'd3,
    OP_AVERAGE = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_RUNNING = 3'd1,
    ST_NO_SAMPLES  = 3'd2,
    ST_ALREADY     = 3'd3,
    ST_ZERO_WINDOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_LATEST,
    SEL_AVG
  } sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LATEST,
    S_WALK,
    S_DRAIN,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [SMP_W-1:0] sample;
    logic [WIN_W-1:0]        window_size;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [SMP_W-1:0] value;
  } out_t;

  typedef struct packed {
    logic    load;
    logic    start_run;
    logic    stop_run;
    logic    insert;
    logic    latest_init;
    logic    avg_init;
    logic    walk;
    logic    div_init;
    logic    div_step;
    logic    res_load;
    sel_t    res_sel;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             running;
    logic             cnt_zero;
    logic             win_zero;
    logic             walk_last;
    logic             div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/rwam_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwam_dp
// Datapath: sample ring, pointers, window accumulator and serial divider.
// ----------------------------------------------------------------------------
module rwam_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rwam_pkg::in_t       in_data,
  input  rwam_pkg::dp_cmd_t   cmd,
  output rwam_pkg::dp_stat_t  stat,
  output rwam_pkg::out_t      out_data
);

  logic [rwam_pkg::SMP_W-1:0] ring [rwam_pkg::DEPTH];

  rwam_pkg::in_t                 in_q_r;
  logic                          running_r, running_nxt;
  logic [rwam_pkg::PTR_W-1:0]    wp_r, wp_nxt;
  logic [rwam_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          acc_v_r;
  logic [rwam_pkg::PTR_W-1:0]    slot_r;
  logic [rwam_pkg::SMP_W-1:0]    rd_data_r;
  logic [rwam_pkg::CNT_W-1:0]    n_r;
  logic [rwam_pkg::CNT_W-1:0]    left_r;
  logic signed [rwam_pkg::SUM_W-1:0] sum_r;
  logic                          neg_r;
  logic [rwam_pkg::SUM_W-1:0]    quo_r;
  logic [rwam_pkg::CNT_W-1:0]    rem_r;
  logic [rwam_pkg::DIV_CW-1:0]   div_cnt_r;
  rwam_pkg::out_t                out_r;

  logic [rwam_pkg::PTR_W-1:0]    prev_wp;
  logic [rwam_pkg::PTR_W-1:0]    prev_slot;
  logic [rwam_pkg::CNT_W-1:0]    n_win;
  logic [rwam_pkg::SUM_W-1:0]    sum_abs;
  logic [rwam_pkg::SUM_W-1:0]    rd_ext;
  logic [rwam_pkg::CNT_W:0]      rem_sh;
  logic [rwam_pkg::CNT_W:0]      rem_diff;
  logic                          rem_ge;
  logic [rwam_pkg::SUM_W-1:0]    quo_sgn;
  logic [rwam_pkg::SMP_W-1:0]    res_value;

  always_comb begin
    prev_wp   = (wp_r == '0) ? rwam_pkg::PTR_W'(rwam_pkg::DEPTH - 1) : wp_r - 1'b1;
    prev_slot = (slot_r == '0) ? rwam_pkg::PTR_W'(rwam_pkg::DEPTH - 1) : slot_r - 1'b1;
    if (in_q_r.window_size < rwam_pkg::WIN_W'(cnt_r)) begin
      n_win = in_q_r.window_size[rwam_pkg::CNT_W-1:0];
    end else begin
      n_win = cnt_r;
    end
    sum_abs  = sum_r[rwam_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
    rd_ext   = {{(rwam_pkg::SUM_W - rwam_pkg::SMP_W){rd_data_r[rwam_pkg::SMP_W-1]}}, rd_data_r};
    rem_sh   = {rem_r, quo_r[rwam_pkg::SUM_W-1]};
    rem_diff = rem_sh - {1'b0, n_r};
    rem_ge   = (rem_sh >= {1'b0, n_r});
    quo_sgn  = neg_r ? (~quo_r + 1'b1) : quo_r;
    unique case (cmd.res_sel)
      rwam_pkg::SEL_LATEST: res_value = rd_data_r;
      rwam_pkg::SEL_AVG:    res_value = quo_sgn[rwam_pkg::SMP_W-1:0];
      default:              res_value = '0;
    endcase
  end

  always_comb begin
    running_nxt = running_r;
    wp_nxt      = wp_r;
    cnt_nxt     = cnt_r;
    if (cmd.start_run) begin
      running_nxt = 1'b1;
    end
    if (cmd.stop_run) begin
      running_nxt = 1'b0;
      wp_nxt      = '0;
      cnt_nxt     = '0;
    end
    if (cmd.insert) begin
      wp_nxt = (wp_r == rwam_pkg::PTR_W'(rwam_pkg::DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (cnt_r < rwam_pkg::CNT_W'(rwam_pkg::DEPTH)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      wp_r      <= '0;
      cnt_r     <= '0;
      acc_v_r   <= 1'b0;
    end else begin
      running_r <= running_nxt;
      wp_r      <= wp_nxt;
      cnt_r     <= cnt_nxt;
      acc_v_r   <= cmd.walk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      ring[wp_r] <= in_q_r.sample;
    end
    rd_data_r <= ring[slot_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q_r <= in_data;
    end
    if (cmd.latest_init) begin
      slot_r <= prev_wp;
    end
    if (cmd.avg_init) begin
      slot_r <= prev_wp;
      n_r    <= n_win;
      left_r <= n_win;
      sum_r  <= '0;
    end
    if (cmd.walk) begin
      slot_r <= prev_slot;
      left_r <= left_r - 1'b1;
    end
    if (acc_v_r) begin
      sum_r <= sum_r + $signed(rd_ext);
    end
    if (cmd.div_init) begin
      neg_r     <= sum_r[rwam_pkg::SUM_W-1];
      quo_r     <= sum_abs;
      rem_r     <= '0;
      div_cnt_r <= rwam_pkg::DIV_CW'(rwam_pkg::SUM_W - 1);
    end
    if (cmd.div_step) begin
      quo_r     <= {quo_r[rwam_pkg::SUM_W-2:0], rem_ge};
      rem_r     <= rem_ge ? rem_diff[rwam_pkg::CNT_W-1:0] : rem_sh[rwam_pkg::CNT_W-1:0];
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (cmd.res_load) begin
      out_r.status <= cmd.res_status;
      out_r.value  <= res_value;
    end
  end

  assign stat.op        = in_q_r.cmd;
  assign stat.running   = running_r;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.win_zero  = (in_q_r.window_size == '0);
  assign stat.walk_last = (left_r == rwam_pkg::CNT_W'(1));
  assign stat.div_last  = (div_cnt_r == '0);
  assign out_data       = out_r;

endmodule
`default_nettype wire

// ===== rtl/rwam_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwam_ctrl
// Controller: decodes each command and sequences the window walk and divide.
// ----------------------------------------------------------------------------
module rwam_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  rwam_pkg::dp_stat_t  stat,
  output rwam_pkg::dp_cmd_t   cmd
);

  rwam_pkg::fsm_t    state_r, state_nxt;
  rwam_pkg::status_t res_st_r, res_st_nxt;
  rwam_pkg::sel_t    sel_r, sel_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rwam_pkg::S_IDLE;
      res_st_r    <= rwam_pkg::ST_OK;
      sel_r       <= rwam_pkg::SEL_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_st_r    <= res_st_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    res_st_nxt     = res_st_r;
    sel_nxt        = sel_r;
    cmd            = '0;
    cmd.res_sel    = sel_r;
    cmd.res_status = res_st_r;
    unique case (state_r)
      rwam_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rwam_pkg::S_DECODE;
        end
      end
      rwam_pkg::S_DECODE: begin
        res_st_nxt = rwam_pkg::ST_OK;
        sel_nxt    = rwam_pkg::SEL_ZERO;
        state_nxt  = rwam_pkg::S_DONE;
        unique case (stat.op)
          rwam_pkg::OP_START: begin
            if (stat.running) begin
              res_st_nxt = rwam_pkg::ST_ALREADY;
            end else begin
              cmd.start_run = 1'b1;
            end
          end
          rwam_pkg::OP_STOP: begin
            if (!stat.running) begin
              res_st_nxt = rwam_pkg::ST_ALREADY;
            end else begin
              cmd.stop_run = 1'b1;
            end
          end
          rwam_pkg::OP_INSERT: begin
            if (!stat.running) begin
              res_st_nxt = rwam_pkg::ST_NOT_RUNNING;
            end else begin
              cmd.insert = 1'b1;
            end
          end
          rwam_pkg::OP_LATEST: begin
            priority if (!stat.running) begin
              res_st_nxt = rwam_pkg::ST_NOT_RUNNING;
            end else if (stat.cnt_zero) begin
              res_st_nxt = rwam_pkg::ST_NO_SAMPLES;
            end else begin
              cmd.latest_init = 1'b1;
              state_nxt       = rwam_pkg::S_LATEST;
            end
          end
          rwam_pkg::OP_AVERAGE: begin
            priority if (!stat.running) begin
              res_st_nxt = rwam_pkg::ST_NOT_RUNNING;
            end else if (stat.cnt_zero) begin
              res_st_nxt = rwam_pkg::ST_NO_SAMPLES;
            end else if (stat.win_zero) begin
              res_st_nxt = rwam_pkg::ST_ZERO_WINDOW;
            end else begin
              cmd.avg_init = 1'b1;
              state_nxt    = rwam_pkg::S_WALK;
            end
          end
          default: begin
          end
        endcase
      end
      rwam_pkg::S_LATEST: begin
        sel_nxt   = rwam_pkg::SEL_LATEST;
        state_nxt = rwam_pkg::S_DONE;
      end
      rwam_pkg::S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_nxt = rwam_pkg::S_DRAIN;
        end
      end
      rwam_pkg::S_DRAIN: begin
        state_nxt = rwam_pkg::S_DIV_INIT;
      end
      rwam_pkg::S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = rwam_pkg::S_DIV;
      end
      rwam_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          sel_nxt   = rwam_pkg::SEL_AVG;
          state_nxt = rwam_pkg::S_DONE;
        end
      end
      rwam_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_load = 1'b1;
          state_nxt    = rwam_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rwam_pkg::S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.res_load | (out_valid_r & out_stall);
  end

  assign in_stall  = (state_r != rwam_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/rssi_window_average_monitor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rssi_window_average_monitor
// Signal-strength monitor that keeps the newest samples in a ring and
// answers start, stop, insert, read-latest and window-average commands.
//
// Each input transaction carries a command, a sample and a window size, and
// produces exactly one output transaction with a status code and a value.
// Transactions move on valid/stall handshakes; one command is in work at a
// time, and in_stall is high from acceptance until the result is loaded into
// the output register.
// Start, stop, insert and error results go from decode straight to the done
// state; read-latest passes through a ring-read state first. An average over
// n samples reads the ring one entry per cycle, then the signed sum goes
// through a restoring divider that retires one quotient bit per cycle.
// The default ring holds 16 entries.
// After reset the monitor is stopped with no samples stored.
// The output register holds a result while out_stall is high, and the next
// command is accepted meanwhile; its result waits until that one is taken.
// ----------------------------------------------------------------------------
module rssi_window_average_monitor (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  rwam_pkg::in_t  in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output rwam_pkg::out_t out_data
);

  rwam_pkg::dp_cmd_t  cmd;
  rwam_pkg::dp_stat_t stat;

  rwam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rwam_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== sim/rssi_window_average_monitor_tb.sv =====
// ----------------------------------------------------------------------------
// rssi_window_average_monitor_tb
// Self-checking testbench for the signal-strength window average monitor.
// A directed pass covers every command, the status codes and the edge
// values. Random sessions of start, insert, read and stop commands follow,
// with some noise. Both channels get random gaps. A predictor works out each
// expected transaction, and a checker compares every output transaction
// against the oldest expected one.
// ----------------------------------------------------------------------------
module rssi_window_average_monitor_tb;

  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int EXP_DEPTH    = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rwam_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rwam_pkg::out_t out_data;

  logic signed [rwam_pkg::SMP_W-1:0] mon_ring [rwam_pkg::DEPTH];
  logic [rwam_pkg::PTR_W-1:0]        mon_wr_ptr = '0;
  logic [rwam_pkg::CNT_W-1:0]        mon_count = '0;
  logic                              mon_running = 1'b0;

  rwam_pkg::out_t expected_reports [EXP_DEPTH];
  int   exp_head = 0;
  int   exp_tail = 0;
  int   mismatches = 0;
  int   items_sent = 0;
  bit   no_gaps = 1'b0;

  rssi_window_average_monitor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  function automatic rwam_pkg::out_t predict_report(rwam_pkg::in_t item);
    rwam_pkg::out_t             rep;
    int                         span;
    int                         acc;
    logic [rwam_pkg::PTR_W-1:0] slot;
    rep.status = rwam_pkg::ST_OK;
    rep.value  = '0;
    case (item.cmd)
      rwam_pkg::OP_START: begin
        if (mon_running) rep.status = rwam_pkg::ST_ALREADY;
        else mon_running = 1'b1;
      end
      rwam_pkg::OP_STOP: begin
        if (!mon_running) begin
          rep.status = rwam_pkg::ST_ALREADY;
        end else begin
          mon_running = 1'b0;
          mon_count   = '0;
          mon_wr_ptr  = '0;
        end
      end
      rwam_pkg::OP_INSERT: begin
        if (!mon_running) begin
          rep.status = rwam_pkg::ST_NOT_RUNNING;
        end else begin
          mon_ring[mon_wr_ptr] = item.sample;
          mon_wr_ptr = (mon_wr_ptr == rwam_pkg::PTR_W'(rwam_pkg::DEPTH - 1)) ?
                       '0 : mon_wr_ptr + 1'b1;
          if (mon_count < rwam_pkg::CNT_W'(rwam_pkg::DEPTH)) mon_count = mon_count + 1'b1;
        end
      end
      rwam_pkg::OP_LATEST: begin
        if (!mon_running) rep.status = rwam_pkg::ST_NOT_RUNNING;
        else if (mon_count == '0) rep.status = rwam_pkg::ST_NO_SAMPLES;
        else rep.value = mon_ring[(mon_wr_ptr == '0) ?
                                  rwam_pkg::PTR_W'(rwam_pkg::DEPTH - 1) : mon_wr_ptr - 1'b1];
      end
      rwam_pkg::OP_AVERAGE: begin
        if (!mon_running) begin
          rep.status = rwam_pkg::ST_NOT_RUNNING;
        end else if (mon_count == '0) begin
          rep.status = rwam_pkg::ST_NO_SAMPLES;
        end else if (item.window_size == '0) begin
          rep.status = rwam_pkg::ST_ZERO_WINDOW;
        end else begin
          span = (item.window_size < rwam_pkg::WIN_W'(mon_count)) ?
                 int'(item.window_size) : int'(mon_count);
          acc  = 0;
          slot = mon_wr_ptr;
          for (int k = 0; k < span; k++) begin
            slot = (slot == '0) ? rwam_pkg::PTR_W'(rwam_pkg::DEPTH - 1) : slot - 1'b1;
            acc += mon_ring[slot];
          end
          rep.value = rwam_pkg::SMP_W'(acc / span);
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic send_cmd(input logic [rwam_pkg::CMD_W-1:0] cmd,
                          input logic signed [rwam_pkg::SMP_W-1:0] smp,
                          input logic [rwam_pkg::WIN_W-1:0] win);
    rwam_pkg::in_t item;
    int            gap;
    item.cmd         = cmd;
    item.sample      = smp;
    item.window_size = win;
    gap = no_gaps ? 0 : int'($urandom_range(0, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_reports[exp_tail % EXP_DEPTH] = predict_report(item);
    exp_tail++;
    items_sent++;
  endtask

  initial begin
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = no_gaps ? 0 : int'($urandom_range(0, 3));
      out_stall <= (hold > 0);
      if (hold > 0) begin
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    rwam_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_head == exp_tail) begin
        if (mismatches < 10)
          $display("unexpected transaction: status %0d value %0d",
                   out_data.status, out_data.value);
        mismatches++;
      end else begin
        want = expected_reports[exp_head % EXP_DEPTH];
        exp_head++;
        if (out_data.status !== want.status || out_data.value !== want.value) begin
          if (mismatches < 10)
            $display("mismatch: expected status %0d value %0d, got status %0d value %0d",
                     want.status, want.value, out_data.status, out_data.value);
          mismatches++;
        end
      end
    end
  end

  function automatic logic signed [rwam_pkg::SMP_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 8'sh7f;
      1: return 8'sh80;
      default: return rwam_pkg::SMP_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [rwam_pkg::WIN_W-1:0] draw_window();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return rwam_pkg::WIN_W'($urandom_range(1, rwam_pkg::DEPTH + 2));
    else if (pick < 8) return rwam_pkg::WIN_W'($urandom_range(0, 16'hffff));
    else if (pick == 8) return '0;
    else return rwam_pkg::WIN_W'(rwam_pkg::DEPTH);
  endfunction

  task automatic test_stopped_state();
    send_cmd(rwam_pkg::OP_STOP, 8'sh00, 16'd1);
    send_cmd(rwam_pkg::OP_INSERT, 8'sh55, 16'd1);
    send_cmd(rwam_pkg::OP_LATEST, 8'sh00, 16'd1);
    send_cmd(rwam_pkg::OP_AVERAGE, 8'sh00, 16'd4);
    send_cmd(rwam_pkg::OP_AVERAGE + 1'b1, 8'sh7f, 16'hffff);
    send_cmd({rwam_pkg::CMD_W{1'b1}}, 8'sh80, 16'h0000);
  endtask

  task automatic test_running_edges();
    send_cmd(rwam_pkg::OP_START, 8'sh00, 16'd0);
    send_cmd(rwam_pkg::OP_START, 8'sh00, 16'd0);
    send_cmd(rwam_pkg::OP_LATEST, 8'sh00, 16'd1);
    send_cmd(rwam_pkg::OP_AVERAGE, 8'sh00, 16'd1);
    send_cmd(rwam_pkg::OP_INSERT, 8'sh7f, 16'd0);
    send_cmd(rwam_pkg::OP_INSERT, 8'sh80, 16'hffff);
    send_cmd(rwam_pkg::OP_AVERAGE, 8'sh00, 16'd0);
    send_cmd(rwam_pkg::OP_AVERAGE, 8'sh00, 16'd2);
    send_cmd(rwam_pkg::OP_INSERT, -8'sd1, 16'd0);
    send_cmd(rwam_pkg::OP_INSERT, -8'sd2, 16'd0);
    send_cmd(rwam_pkg::OP_AVERAGE, 8'sh00, 16'd2);
    send_cmd(rwam_pkg::OP_AVERAGE, 8'sh00, 16'hffff);
    send_cmd(rwam_pkg::OP_LATEST, 8'sh00, 16'd0);
    send_cmd(rwam_pkg::OP_AVERAGE + 2'd2, 8'sh12, 16'd3);
    send_cmd(rwam_pkg::OP_STOP, 8'sh00, 16'd0);
    send_cmd(rwam_pkg::OP_LATEST, 8'sh00, 16'd1);
    send_cmd(rwam_pkg::OP_STOP, 8'sh00, 16'd0);
  endtask

  task automatic test_random_sessions();
    int ops;
    int pick;
    while (items_sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        send_cmd(rwam_pkg::OP_START, draw_sample(), draw_window());
        ops = $urandom_range(1, 40);
        repeat (ops) begin
          pick = $urandom_range(0, 99);
          if (pick < 50) send_cmd(rwam_pkg::OP_INSERT, draw_sample(), draw_window());
          else if (pick < 80) send_cmd(rwam_pkg::OP_AVERAGE, draw_sample(), draw_window());
          else if (pick < 95) send_cmd(rwam_pkg::OP_LATEST, draw_sample(), draw_window());
          else send_cmd(rwam_pkg::CMD_W'($urandom_range(0, 7)), draw_sample(),
                        rwam_pkg::WIN_W'($urandom_range(0, 16'hffff)));
        end
        if ($urandom_range(0, 1) == 0)
          send_cmd(rwam_pkg::OP_STOP, draw_sample(), draw_window());
      end else begin
        repeat ($urandom_range(1, 6))
          send_cmd(rwam_pkg::CMD_W'($urandom_range(0, 7)), draw_sample(),
                   rwam_pkg::WIN_W'($urandom_range(0, 16'hffff)));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stopped_state();
    test_running_edges();
    test_random_sessions();
    in_valid <= 1'b0;
    waited = 0;
    while (exp_head != exp_tail && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (exp_head != exp_tail) begin
      $display("%0d expected transactions never arrived", exp_tail - exp_head);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rwam_pkg.sv
rtl/rwam_dp.sv
rtl/rwam_ctrl.sv
rtl/rssi_window_average_monitor.sv
sim/rssi_window_average_monitor_tb.sv
